[rtl/i2da_pkg.sv]
`default_nettype none

package i2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int SPACE_W    = 8;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int NEED_W     = CNT_W + 1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic dshift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/i2da_cell.sv]
`default_nettype none

module i2da_cell
    import i2da_pkg::*;
(
    input  wire        aclk,
    input  cell_ctrl_t ctrl,
    input  wire        bit_in,
    input  digit_t     digit_in,
    output logic       bit_out,
    output digit_t     digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    always_comb begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        bit_out = adj[DIGIT_W-1];
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end else if (ctrl.dshift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

[rtl/int32_to_decimal_ascii.sv]
`default_nettype none

// Signed 32-bit integer to ASCII decimal text. An input transaction carries
// the value in s_tdata[31:0] and the destination size (slots including the
// terminator) in s_tdata[39:32]. The block answers with one output
// transaction per character: an optional '-', the digits with no leading
// zeros, then a NUL with m_tlast set; m_tuser is 1 on all of them. If the text
// does not fit, it answers with a single transaction carrying 0, m_tuser 0
// and m_tlast 1. One item is worked at a time: it is accepted, then the
// magnitude is shifted through the row of ten BCD digit cells (one binary
// bit per cycle, shift-add-3), leading zeros are dropped, and then the
// characters go out one per cycle while the output side does not stall.
module int32_to_decimal_ascii
    import i2da_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [39:0]       s_tdata,   // value[31:0], space[39:32]
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // char_out[7:0]
    output logic [0:0]        m_tuser,   // ok[0]
    output logic              m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_STRIP = 3'd2;
    localparam logic [2:0] ST_FAIL  = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_DIG   = 3'd5;
    localparam logic [2:0] ST_NUL   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic                 neg_reg, neg_next;
    logic [SPACE_W-1:0]   space_reg, space_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]     ndig_reg, ndig_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]    m_char_reg, m_char_next;
    logic                 m_ok_reg, m_ok_next;
    logic                 m_last_reg, m_last_next;

    cell_ctrl_t           ctrl;
    logic                 cell_bit [NUM_DIGITS+1];
    digit_t               cell_digit [NUM_DIGITS+1];
    digit_t               top_digit;
    logic                 out_free;
    logic [NEED_W-1:0]    need;
    logic [VALUE_W-1:0]   in_value;

    assign cell_bit[0]   = bin_reg[VALUE_W-1];
    assign cell_digit[0] = '0;
    assign top_digit     = cell_digit[NUM_DIGITS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
            i2da_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .bit_in   (cell_bit[gi]),
                .digit_in (cell_digit[gi]),
                .bit_out  (cell_bit[gi+1]),
                .digit    (cell_digit[gi+1])
            );
        end
    endgenerate

    assign out_free = !m_tvalid_reg || m_tready;
    assign need     = NEED_W'(neg_reg) + NEED_W'(ndig_reg) + NEED_W'(1);
    assign in_value = s_tdata[VALUE_W-1:0];

    always_comb begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        neg_next      = neg_reg;
        space_next    = space_reg;
        bit_cnt_next  = bit_cnt_reg;
        ndig_next     = ndig_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_ok_next     = m_ok_reg;
        m_last_next   = m_last_reg;
        ctrl          = '0;
        s_tready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next     = in_value[VALUE_W-1];
                    bin_next     = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
                    space_next   = s_tdata[VALUE_W+SPACE_W-1:VALUE_W];
                    bit_cnt_next = BIT_CNT_W'(VALUE_W - 1);
                    ndig_next    = CNT_W'(NUM_DIGITS);
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.dabble = 1'b1;
                bin_next    = {bin_reg[VALUE_W-2:0], 1'b0};
                if (bit_cnt_reg == '0) begin
                    state_next = ST_STRIP;
                end else begin
                    bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                end
            end
            ST_STRIP: begin
                if (top_digit == '0 && ndig_reg != CNT_W'(1)) begin
                    ctrl.dshift = 1'b1;
                    ndig_next   = ndig_reg - CNT_W'(1);
                end else if (SPACE_W'(need) > space_reg) begin
                    state_next = ST_FAIL;
                end else if (neg_reg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DIG;
                end
            end
            ST_FAIL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = CHAR_NUL;
                    m_ok_next     = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = CHAR_MINUS;
                    m_ok_next     = 1'b1;
                    m_last_next   = 1'b0;
                    state_next    = ST_DIG;
                end
            end
            ST_DIG: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = CHAR_ZERO + CHAR_W'(top_digit);
                    m_ok_next     = 1'b1;
                    m_last_next   = 1'b0;
                    ctrl.dshift   = 1'b1;
                    ndig_next     = ndig_reg - CNT_W'(1);
                    if (ndig_reg == CNT_W'(1)) begin
                        state_next = ST_NUL;
                    end
                end
            end
            ST_NUL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = CHAR_NUL;
                    m_ok_next     = 1'b1;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        bin_reg     <= bin_next;
        neg_reg     <= neg_next;
        space_reg   <= space_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
        m_char_reg  <= m_char_next;
        m_ok_reg    <= m_ok_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_char_reg;
    assign m_tuser[0] = m_ok_reg;
    assign m_tlast    = m_last_reg;

endmodule

`default_nettype wire

[dv/tb_int32_to_decimal_ascii.sv]
`default_nettype none

module tb_int32_to_decimal_ascii;
    import i2da_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [SPACE_W-1:0] space;
        bit                 calm;
    } conv_req_t;

    typedef struct {
        logic [CHAR_W-1:0] char_out;
        logic              ok;
        logic              last;
    } text_char_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    wire               s_tready;
    logic [39:0]       s_tdata = '0;   // value[31:0], space[39:32]
    wire               m_tvalid;
    logic              m_tready = 1'b0;
    wire  [CHAR_W-1:0] m_tdata;        // char_out[7:0]
    wire  [0:0]        m_tuser;        // ok[0]
    wire               m_tlast;

    conv_req_t  pending_reqs[$];
    text_char_t expected_chars[$];
    int         errors = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         calm = 1'b0;

    int32_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit calm_mode);
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                         input logic [SPACE_W-1:0] space);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] digits[NUM_DIGITS];
        int                 ndig;
        int                 need;
        text_char_t         c;
        neg = value[VALUE_W-1];
        mag = neg ? (VALUE_W'(0) - value) : value;
        rest = mag;
        ndig = 0;
        do begin
            digits[ndig] = DIGIT_W'(rest % 10);
            ndig++;
            rest = rest / 10;
        end while (rest != 0 && ndig < NUM_DIGITS);
        need = (neg ? 1 : 0) + ndig + 1;
        if (int'(space) < need) begin
            c.char_out = CHAR_NUL;
            c.ok = 1'b0;
            c.last = 1'b1;
            expected_chars.push_back(c);
            return;
        end
        c.ok = 1'b1;
        c.last = 1'b0;
        if (neg) begin
            c.char_out = CHAR_MINUS;
            expected_chars.push_back(c);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            c.char_out = CHAR_ZERO + CHAR_W'(digits[i]);
            expected_chars.push_back(c);
        end
        c.char_out = CHAR_NUL;
        c.last = 1'b1;
        expected_chars.push_back(c);
    endfunction

    task automatic add_req(input logic [VALUE_W-1:0] value, input logic [SPACE_W-1:0] space,
                           input bit calm_mode);
        conv_req_t r;
        r.value = value;
        r.space = space;
        r.calm = calm_mode;
        pending_reqs.push_back(r);
    endtask

    always @(posedge aclk) begin
        conv_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                predict_text(s_tdata[31:0], s_tdata[39:32]);
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {r.space, r.value};
                calm <= r.calm;
                send_gap = pick_gap(r.calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        text_char_t c;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("output transaction with nothing expected: char_out %h ok %b last %b",
                       m_tdata, m_tuser[0], m_tlast);
                errors++;
            end else begin
                c = expected_chars.pop_front();
                if (m_tdata !== c.char_out) begin
                    $error("char_out: expected %h, actual %h", c.char_out, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== c.ok) begin
                    $error("ok: expected %b, actual %b", c.ok, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== c.last) begin
                    $error("last: expected %b, actual %b", c.last, m_tlast);
                    errors++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_gap = pick_gap(calm);
        end
    end

    initial begin
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] val;
        logic [SPACE_W-1:0] space;
        longint             lim;
        int                 ndig;
        int                 r;

        add_req(32'd0, 8'd0, 1'b0);
        add_req(32'd0, 8'd1, 1'b0);
        add_req(32'd0, 8'd2, 1'b0);
        add_req(32'hFFFF_FFFF, 8'd2, 1'b0);
        add_req(32'hFFFF_FFFF, 8'd3, 1'b0);
        add_req(32'h8000_0000, 8'd11, 1'b0);
        add_req(32'h8000_0000, 8'd12, 1'b0);
        add_req(32'h8000_0000, 8'd255, 1'b0);
        add_req(32'h7FFF_FFFF, 8'd10, 1'b0);
        add_req(32'h7FFF_FFFF, 8'd11, 1'b0);
        add_req(32'h7FFF_FFFF, 8'd255, 1'b0);
        add_req(32'd9, 8'd2, 1'b0);
        add_req(32'd10, 8'd2, 1'b0);
        add_req(32'd10, 8'd3, 1'b0);
        add_req(-32'sd9, 8'd3, 1'b0);
        add_req(-32'sd10, 8'd3, 1'b0);
        add_req(32'd1_000_000_000, 8'd11, 1'b0);
        add_req(32'd999_999_999, 8'd10, 1'b0);
        add_req(32'd999_999_999, 8'd9, 1'b0);
        add_req(-32'sd1_000_000_000, 8'd12, 1'b0);
        add_req(-32'sd1_000_000_000, 8'd11, 1'b0);
        add_req(32'd1234567890, 8'd0, 1'b0);
        add_req(32'h5555_5555, 8'hAA, 1'b0);
        add_req(32'hAAAA_AAAA, 8'h55, 1'b0);

        for (int i = 0; i < 206; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                val = $urandom;
            end else begin
                ndig = $urandom_range(1, NUM_DIGITS);
                lim = 1;
                for (int k = 0; k < ndig; k++)
                    lim = lim * 10;
                mag = (ndig == NUM_DIGITS) ? $urandom : VALUE_W'(longint'($urandom) % lim);
                val = $urandom_range(0, 1) ? (VALUE_W'(0) - mag) : mag;
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                space = SPACE_W'($urandom_range(0, 13));
            else if (r < 55)
                space = 8'd255;
            else
                space = SPACE_W'($urandom_range(0, 255));
            add_req(val, space, (i >= 60 && i < 100) || (i >= 170 && i < 200));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (errors == 0 && expected_chars.size() == 0)
            $display("int32_to_decimal_ascii test passed");
        else
            $display("int32_to_decimal_ascii test failed");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("int32_to_decimal_ascii test failed");
        $finish;
    end

endmodule

`default_nettype wire
